// ----- sv/smva_pkg.sv -----
// Shared constants for the sparse matrix-vector accumulate block.
// Holds parameter defaults, field widths, item function codes and register indexes.
// No dependencies.
package smva_pkg;

  // Parameter defaults
  localparam int VECTOR_DEPTH_DEF  = 1024;
  localparam int FRACTION_BITS_DEF = 16;

  // Fixed field widths
  localparam int FUNC_W  = 3;
  localparam int IDX_W   = 10;
  localparam int DATA_W  = 32;
  localparam int ACC_W   = 64;
  localparam int Q_W     = 35;
  localparam int SUM_W   = 36;
  localparam int PADDR_W = 3;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_WR_X = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_Y = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_NZ   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RD_X = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RD_Y = 3'd4;

  // Register indexes
  localparam logic [0:0] REG_DIRECTION_MODE = 1'b0;

endpackage

// ----- sv/smva_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// Read-first on a write cycle; no dependencies.
module smva_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/sparse_matvec_accumulate.sv -----
// Sparse matrix-vector accumulate: x and y vectors in two RAMs, one 64-bit row sum.
// Writes and undefined codes answer from the accepting S_IDLE step, reads from S_READ,
// nonzero entries from S_ACC, or from S_ADD after S_RND on the last entry of a row.
// One item at a time: busy holds off start through the read-multiply-accumulate-writeback sequence.
// Reset (rst_n low, synchronous) clears the sequencer, row sum and mode; RAMs are not cleared.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module sparse_matvec_accumulate
  import smva_pkg::*;
#(
  parameter int VECTOR_DEPTH  = VECTOR_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Item command channel
  input  logic                     start,
  output logic                     busy,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [IDX_W-1:0]         in_col_index,
  input  logic [IDX_W-1:0]         in_row_index,
  input  logic signed [DATA_W-1:0] in_data_value,
  input  logic                     in_row_last,
  // Result channel
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic                     out_saturated,
  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int ADDR_W = $clog2(VECTOR_DEPTH);
  localparam int RB     = (FRACTION_BITS == 0) ? 0 : FRACTION_BITS - 1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] Q_LIM   = 64'sd8589934592;
  localparam logic signed [SUM_W-1:0] T_MAX   = 36'sd2147483647;
  localparam logic signed [SUM_W-1:0] T_MIN   = -36'sd2147483648;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ACC,
    S_RND,
    S_ADD
  } state_t;

  // Configuration register
  logic mode_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[PADDR_W-1] == REG_DIRECTION_MODE && paddr[1:0] == 2'b00) ?
                  {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr && paddr[PADDR_W-1] == REG_DIRECTION_MODE && paddr[1:0] == 2'b00) begin
      mode_r <= pwdata[0];
    end
  end

  // Sequencer and datapath registers
  state_t                    state_r;
  logic [FUNC_W-1:0]         func_r;
  logic                      col_ok_r;
  logic                      row_ok_r;
  logic [ADDR_W-1:0]         row_addr_r;
  logic signed [DATA_W-1:0]  coef_r;
  logic                      last_r;
  logic signed [ACC_W-1:0]   prod_r;
  logic signed [DATA_W-1:0]  dst_r;
  logic signed [ACC_W-1:0]   row_sum_r;
  logic signed [Q_W-1:0]     q_r;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_value_r;
  logic                      out_sat_r;

  logic                      accept;
  logic                      in_col_ok;
  logic                      in_row_ok;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start & ~busy;
  assign in_col_ok = ({{(32-IDX_W){1'b0}}, in_col_index} < 32'(VECTOR_DEPTH));
  assign in_row_ok = ({{(32-IDX_W){1'b0}}, in_row_index} < 32'(VECTOR_DEPTH));

  // RAM ports
  logic              x_we, y_we;
  logic [ADDR_W-1:0] x_addr, y_addr;
  logic [DATA_W-1:0] x_wdata, y_wdata;
  logic [DATA_W-1:0] x_rdata, y_rdata;

  // Datapath combinational values
  logic signed [DATA_W-1:0] src_c;
  logic signed [DATA_W-1:0] dst_c;
  logic signed [ACC_W-1:0]  prod_c;
  logic signed [ACC_W-1:0]  sum_raw_c;
  logic signed [ACC_W-1:0]  sum_c;
  logic signed [ACC_W-1:0]  rnd_c;
  logic signed [ACC_W-1:0]  clamp_c;
  logic signed [SUM_W-1:0]  t_c;
  logic signed [DATA_W-1:0] t_clip_c;
  logic                     t_sat_c;
  logic                     ent_x_src;

  // Source and destination selection, product
  always_comb begin
    src_c  = mode_r ? signed'(y_rdata) : signed'(x_rdata);
    dst_c  = mode_r ? signed'(x_rdata) : signed'(y_rdata);
    prod_c = coef_r * src_c;
  end

  // Saturating accumulate
  always_comb begin
    sum_raw_c = row_sum_r + prod_r;
    if (row_sum_r[ACC_W-1] == prod_r[ACC_W-1] && sum_raw_c[ACC_W-1] != row_sum_r[ACC_W-1]) begin
      sum_c = row_sum_r[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_c = sum_raw_c;
    end
  end

  // Round half up, then clamp to +/-2^33 so the 36-bit destination add cannot overflow
  always_comb begin
    if (FRACTION_BITS == 0) begin
      rnd_c = row_sum_r;
    end else begin
      rnd_c = (row_sum_r >>> FRACTION_BITS) + signed'({{(ACC_W-1){1'b0}}, row_sum_r[RB]});
    end
    if (rnd_c > Q_LIM) begin
      clamp_c = Q_LIM;
    end else if (rnd_c < -Q_LIM) begin
      clamp_c = -Q_LIM;
    end else begin
      clamp_c = rnd_c;
    end
  end

  // Destination update with clipping
  always_comb begin
    t_c = SUM_W'(dst_r) + SUM_W'(q_r);
    if (t_c > T_MAX) begin
      t_clip_c = DATA_W'(T_MAX);
      t_sat_c  = 1'b1;
    end else if (t_c < T_MIN) begin
      t_clip_c = DATA_W'(T_MIN);
      t_sat_c  = 1'b1;
    end else begin
      t_clip_c = DATA_W'(t_c);
      t_sat_c  = 1'b0;
    end
  end

  // Address and write-enable steering for both vector RAMs
  always_comb begin
    ent_x_src = (in_func == FUNC_NZ) ? ~mode_r : 1'b1;
    x_addr    = ent_x_src ? ADDR_W'(in_col_index) : ADDR_W'(in_row_index);
    y_addr    = (in_func == FUNC_NZ && !mode_r) ? ADDR_W'(in_row_index) :
                ADDR_W'(in_col_index);
    x_we      = accept & (in_func == FUNC_WR_X) & in_col_ok;
    y_we      = accept & (in_func == FUNC_WR_Y) & in_col_ok;
    x_wdata   = in_data_value;
    y_wdata   = in_data_value;
    if (state_r == S_ADD) begin
      x_addr  = row_addr_r;
      y_addr  = row_addr_r;
      x_we    = row_ok_r & mode_r;
      y_we    = row_ok_r & ~mode_r;
      x_wdata = t_clip_c;
      y_wdata = t_clip_c;
    end
  end

  smva_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .addr  (x_addr),
    .wdata (x_wdata),
    .rdata (x_rdata)
  );

  smva_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_y_ram (
    .clk   (clk),
    .we    (y_we),
    .addr  (y_addr),
    .wdata (y_wdata),
    .rdata (y_rdata)
  );

  // Sequencer: state, datapath and registered result outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_sum_r   <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r     <= in_func;
            col_ok_r   <= in_col_ok;
            row_ok_r   <= in_row_ok;
            row_addr_r <= ADDR_W'(in_row_index);
            coef_r     <= in_data_value;
            last_r     <= in_row_last;
            priority if (in_func == FUNC_WR_X || in_func == FUNC_WR_Y) begin
              // Writes answer with the written value
              out_valid_r <= 1'b1;
              out_value_r <= in_data_value;
              out_sat_r   <= 1'b0;
            end else if (in_func == FUNC_NZ || in_func == FUNC_RD_X ||
                         in_func == FUNC_RD_Y) begin
              state_r <= S_READ;
            end else begin
              // Undefined code: answer zero, no state change
              out_valid_r <= 1'b1;
              out_value_r <= '0;
              out_sat_r   <= 1'b0;
            end
          end
        end
        S_READ: begin
          if (func_r == FUNC_NZ) begin
            prod_r  <= col_ok_r ? prod_c : '0;
            dst_r   <= dst_c;
            state_r <= S_ACC;
          end else begin
            out_valid_r <= 1'b1;
            out_sat_r   <= 1'b0;
            if (!col_ok_r) begin
              out_value_r <= '0;
            end else if (func_r == FUNC_RD_X) begin
              out_value_r <= x_rdata;
            end else begin
              out_value_r <= y_rdata;
            end
            state_r <= S_IDLE;
          end
        end
        S_ACC: begin
          row_sum_r <= sum_c;
          if (last_r) begin
            state_r <= S_RND;
          end else begin
            out_valid_r <= 1'b1;
            out_value_r <= row_ok_r ? dst_r : '0;
            out_sat_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_RND: begin
          q_r       <= Q_W'(clamp_c);
          row_sum_r <= '0;
          state_r   <= S_ADD;
        end
        S_ADD: begin
          // Write back happens through the RAM port steering
          out_valid_r <= 1'b1;
          out_value_r <= row_ok_r ? t_clip_c : '0;
          out_sat_r   <= row_ok_r & t_sat_c;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_saturated    = out_sat_r;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for sparse_matvec_accumulate: loads, reads, row-streamed nonzero entries
// and direction changes, each result checked against a typed expectation or an in-bench fixed-point predictor.
// Depends on smva_pkg and the sparse_matvec_accumulate RTL only.
module tb_top;
  import smva_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_GAP       = 18;
  localparam int PHASES        = 4;
  localparam int PHASE_ITEMS   = 110;

  // Codes the package leaves undefined
  localparam logic [FUNC_W-1:0] FUNC_RSVD_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

  // Register map: register i at byte address 4*i
  localparam logic [PADDR_W-1:0] MODE_ADDR   = {REG_DIRECTION_MODE, 2'b00};
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = 3'd4;

  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint Q_LIMIT = 64'sd1 <<< 33;
  localparam longint D_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint D_MIN   = -D_MAX - 1;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              sat;
  } element_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
    logic [DATA_W-1:0] data;
    logic              last;
    logic              typed;
    logic [DATA_W-1:0] want;
    logic              want_sat;
  } stim_row_t;

  localparam int DIR_ROWS = 23;

  // Directed items; typed expectations only where the answer is obvious
  stim_row_t dir_table [DIR_ROWS] = '{
    '{FUNC_WR_X, 10'd0, 10'd0, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{FUNC_WR_X, 10'd1023, 10'd0, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
    '{FUNC_WR_Y, 10'd0, 10'd0, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{FUNC_WR_Y, 10'd1023, 10'd0, 32'h0001_0000, 1'b0, 1'b1, 32'h0001_0000, 1'b0},
    '{FUNC_RD_X, 10'd0, 10'd1023, 32'h0000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{FUNC_RD_Y, 10'd1023, 10'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0001_0000, 1'b0},
    '{FUNC_RSVD_5, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 1'b0},
    '{FUNC_RSVD_6, 10'h155, 10'h2AA, 32'h8000_0000, 1'b0, 1'b1, 32'h0, 1'b0},
    '{FUNC_RSVD_7, 10'd0, 10'd0, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 1'b0},
    '{FUNC_WR_X, 10'h155, 10'd0, 32'h0002_0000, 1'b0, 1'b1, 32'h0002_0000, 1'b0},
    '{FUNC_WR_Y, 10'h2AA, 10'd0, 32'hFFFF_0000, 1'b0, 1'b1, 32'hFFFF_0000, 1'b0},
    // two-entry row with a read in between
    '{FUNC_NZ, 10'h155, 10'h2AA, 32'h0000_8000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FUNC_RD_X, 10'h155, 10'd0, 32'h0000_0000, 1'b0, 1'b1, 32'h0002_0000, 1'b0},
    '{FUNC_NZ, 10'h155, 10'h2AA, 32'h0001_8000, 1'b1, 1'b0, 32'h0, 1'b0},
    // accumulator saturates high, update clips high
    '{FUNC_NZ, 10'd0, 10'd1023, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FUNC_NZ, 10'd0, 10'd1023, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FUNC_NZ, 10'd0, 10'd1023, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
    // large negative sum clips low
    '{FUNC_NZ, 10'd1023, 10'd0, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
    // rounding ties: +half goes up, -half goes to zero
    '{FUNC_WR_X, 10'd1, 10'd0, 32'h0000_0001, 1'b0, 1'b1, 32'h0000_0001, 1'b0},
    '{FUNC_WR_Y, 10'd1, 10'd0, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{FUNC_NZ, 10'd1, 10'd1, 32'h0000_8000, 1'b1, 1'b0, 32'h0, 1'b0},
    '{FUNC_NZ, 10'd1, 10'd1, 32'hFFFF_8000, 1'b1, 1'b0, 32'h0, 1'b0},
    // leave a row open across the direction change
    '{FUNC_NZ, 10'h155, 10'h2AA, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [FUNC_W-1:0] in_func;
  logic [IDX_W-1:0] in_col_index;
  logic [IDX_W-1:0] in_row_index;
  logic signed [DATA_W-1:0] in_data_value;
  logic in_row_last;
  logic out_valid;
  logic signed [DATA_W-1:0] out_result_value;
  logic out_saturated;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // Predictor state
  logic signed [DATA_W-1:0] vec_x [VECTOR_DEPTH_DEF];
  logic signed [DATA_W-1:0] vec_y [VECTOR_DEPTH_DEF];
  longint row_acc;
  logic dir_mode;

  // Indexes known to be written, so reads never touch undefined elements
  bit x_written [VECTOR_DEPTH_DEF];
  bit y_written [VECTOR_DEPTH_DEF];
  logic [IDX_W-1:0] x_pool [$];
  logic [IDX_W-1:0] y_pool [$];

  element_result_t pending_results [$];

  int err_count;
  int items_sent;
  int rows_closed;
  int results_checked;
  int clipped_seen;
  int calm_left;

  sparse_matvec_accumulate i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_col_index     (in_col_index),
    .in_row_index     (in_row_index),
    .in_data_value    (in_data_value),
    .in_row_last      (in_row_last),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_saturated    (out_saturated),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // Fixed-point model of one item; updates vectors, row sum and returns the result
  function automatic void compute_matvec_result(
    input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] r,
    input logic signed [DATA_W-1:0] d, input logic l,
    output logic [DATA_W-1:0] val, output logic sat);
    longint prod;
    longint q;
    longint t;
    longint dst_v;
    logic signed [DATA_W-1:0] src_v;
    val = '0;
    sat = 1'b0;
    // 10-bit indexes always fall inside the 1024-deep vectors
    case (f)
      FUNC_WR_X: begin
        vec_x[c] = d;
        val = d;
      end
      FUNC_WR_Y: begin
        vec_y[c] = d;
        val = d;
      end
      FUNC_RD_X: val = vec_x[c];
      FUNC_RD_Y: val = vec_y[c];
      FUNC_NZ: begin
        src_v = dir_mode ? vec_y[c] : vec_x[c];
        dst_v = dir_mode ? longint'(vec_x[r]) : longint'(vec_y[r]);
        prod = longint'(d) * longint'(src_v);
        // saturating accumulate
        if (prod > 0 && row_acc > ACC_MAX - prod) row_acc = ACC_MAX;
        else if (prod < 0 && row_acc < ACC_MIN - prod) row_acc = ACC_MIN;
        else row_acc = row_acc + prod;
        if (l) begin
          // round half up back to element format, then clip into destination
          q = (row_acc >>> FRACTION_BITS_DEF) + longint'(row_acc[FRACTION_BITS_DEF-1]);
          row_acc = 0;
          if (q > Q_LIMIT) q = Q_LIMIT;
          if (q < -Q_LIMIT) q = -Q_LIMIT;
          t = dst_v + q;
          if (t > D_MAX) begin
            t = D_MAX;
            sat = 1'b1;
          end else if (t < D_MIN) begin
            t = D_MIN;
            sat = 1'b1;
          end
          if (dir_mode) vec_x[r] = t[DATA_W-1:0];
          else vec_y[r] = t[DATA_W-1:0];
          val = t[DATA_W-1:0];
        end else begin
          val = dst_v[DATA_W-1:0];
        end
      end
      default: ;
    endcase
  endfunction

  // Issue one item at a posedge, hold until the transfer, then log its expectation
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] c,
                           input logic [IDX_W-1:0] r, input logic [DATA_W-1:0] d,
                           input logic l, input logic typed,
                           input logic [DATA_W-1:0] want, input logic want_sat);
    int gap;
    element_result_t er;
    logic [DATA_W-1:0] pv;
    logic ps;
    gap = (calm_left > 0) ? 0 : $urandom_range(0, MAX_GAP);
    if (calm_left > 0) calm_left--;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_col_index <= c;
    in_row_index <= r;
    in_data_value <= d;
    in_row_last <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    compute_matvec_result(f, c, r, d, l, pv, ps);
    er.value = typed ? want : pv;
    er.sat = typed ? want_sat : ps;
    pending_results = {pending_results, er};
    items_sent++;
    if (f == FUNC_NZ && l) rows_closed++;
    if (f == FUNC_WR_X && !x_written[c]) begin
      x_written[c] = 1'b1;
      x_pool = {x_pool, c};
    end
    if (f == FUNC_WR_Y && !y_written[c]) begin
      y_written[c] = 1'b1;
      y_pool = {y_pool, c};
    end
  endtask

  // Drop start and hold until every expected result has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == MODE_ADDR) dir_mode = data[0];
  endtask

  task automatic cfg_check_mode();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MODE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {31'b0, dir_mode}) report_mismatch("mode readback", prdata, {31'b0, dir_mode});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_written(input bit from_y);
    if (from_y) return y_pool[$urandom_range(0, y_pool.size() - 1)];
    return x_pool[$urandom_range(0, x_pool.size() - 1)];
  endfunction

  // Modest Q16.16 values, some wide ones, the extremes and fully random words
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    if (sel < 6) return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
    if (sel == 6) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom();
  endfunction

  // Random traffic: mostly whole matrix rows, plus loads, reads and stray codes
  task automatic run_phase(input int n_items, input bit with_pause);
    int sent;
    int len;
    int sel;
    logic [IDX_W-1:0] dest;
    logic [FUNC_W-1:0] f;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(5, 30);
      if (with_pause && sent >= n_items / 2) begin
        wait_drained();
        with_pause = 1'b0;
      end
      sel = $urandom_range(0, 19);
      if (sel < 11) begin
        len = $urandom_range(1, 5);
        dest = pick_written(!dir_mode);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            f = $urandom_range(0, 1) ? FUNC_RD_Y : FUNC_RD_X;
            send_item(f, pick_written(f == FUNC_RD_Y), IDX_W'($urandom()), $urandom(),
                      1'($urandom()), 1'b0, '0, 1'b0);
            sent++;
          end
          // occasionally break the row by switching destination mid-row
          if ($urandom_range(0, 5) == 0) dest = pick_written(!dir_mode);
          send_item(FUNC_NZ, pick_written(dir_mode), dest, pick_value(), k == len - 1,
                    1'b0, '0, 1'b0);
          sent++;
        end
      end else if (sel < 15) begin
        f = $urandom_range(0, 1) ? FUNC_WR_Y : FUNC_WR_X;
        send_item(f, IDX_W'($urandom()), IDX_W'($urandom()), pick_value(),
                  1'($urandom()), 1'b0, '0, 1'b0);
        sent++;
      end else if (sel < 18) begin
        f = $urandom_range(0, 1) ? FUNC_RD_Y : FUNC_RD_X;
        send_item(f, pick_written(f == FUNC_RD_Y), IDX_W'($urandom()), $urandom(),
                  1'($urandom()), 1'b0, '0, 1'b0);
        sent++;
      end else if (sel == 18) begin
        case ($urandom_range(0, 2))
          0: f = FUNC_RSVD_5;
          1: f = FUNC_RSVD_6;
          default: f = FUNC_RSVD_7;
        endcase
        send_item(f, IDX_W'($urandom()), IDX_W'($urandom()), $urandom(), 1'($urandom()),
                  1'b0, '0, 1'b0);
        sent++;
      end else begin
        send_item(FUNC_NZ, pick_written(dir_mode), pick_written(!dir_mode), pick_value(),
                  1'($urandom()), 1'b0, '0, 1'b0);
        sent++;
      end
    end
  endtask

  // Compare each result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    element_result_t expected_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_result_value, '0);
      end else begin
        expected_r = pending_results.pop_front();
        if (out_result_value !== expected_r.value)
          report_mismatch("result_value", out_result_value, expected_r.value);
        if (out_saturated !== expected_r.sat)
          report_mismatch("saturated", {31'b0, out_saturated}, {31'b0, expected_r.sat});
        results_checked++;
        if (out_saturated === 1'b1) clipped_seen++;
      end
    end
  end

  initial begin
    err_count = 0;
    items_sent = 0;
    rows_closed = 0;
    results_checked = 0;
    clipped_seen = 0;
    calm_left = 0;
    row_acc = 0;
    dir_mode = 1'b0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_func <= FUNC_WR_X;
    in_col_index <= '0;
    in_row_index <= '0;
    in_data_value <= '0;
    in_row_last <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    cfg_check_mode();
    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_table[i].func, dir_table[i].col, dir_table[i].row, dir_table[i].data,
                dir_table[i].last, dir_table[i].typed, dir_table[i].want,
                dir_table[i].want_sat);
    wait_drained();

    // flip direction with a row still open; unused address must have no effect
    cfg_write(MODE_ADDR, 32'd1);
    cfg_write(UNUSED_ADDR, 32'd0);
    cfg_check_mode();

    // random phases alternate direction
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        cfg_write(MODE_ADDR, {31'b0, (p % 2 == 0)});
        cfg_check_mode();
      end
      run_phase(PHASE_ITEMS, p == 0);
    end
    wait_drained();

    $display("Run covered %0d items over %0d direction phases: %0d rows closed,",
             items_sent, PHASES, rows_closed);
    $display("%0d results checked, %0d of them clipped.", results_checked, clipped_seen);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Timeout waiting for the block");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
